FILE: rtl/core/genotypic_value_accumulator_macros.svh
// ----------------------------------------------------------------------------
// genotypic value accumulator assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GENOTYPIC_VALUE_ACCUMULATOR_MACROS_SVH
`define GENOTYPIC_VALUE_ACCUMULATOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define GVA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gva check failed");
// next-cycle implication
`define GVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gva check failed");
`else
`define GVA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GVA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/gva_pkg.sv
// ----------------------------------------------------------------------------
// gva_pkg
// shared types and constants of the genotypic value accumulator
// ----------------------------------------------------------------------------
package gva_pkg;

  localparam int EFFECT_W = 32;
  localparam int SUM_W    = 48;
  localparam int TALLY_W  = 12;
  localparam int DOM_W    = 16;
  localparam int LOCI_W   = 6;
  localparam int HAP_W    = 32;
  localparam int PIECE_W  = 6;
  localparam int LOCUS_W  = 5;
  localparam int FRAC_DOM = 12;

  localparam logic [DOM_W-1:0]   DOM_RESET     = 16'd2048;
  localparam logic [LOCI_W-1:0]  LOCI_RESET    = 6'd32;
  localparam logic [TALLY_W-1:0] TALLY_MAX     = 12'd4095;
  localparam logic [TALLY_W-1:0] EPI_THRESHOLD = 12'd2;

  typedef enum logic {
    REQ_LOAD     = 1'b0,
    REQ_GENOTYPE = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    REG_DOMINANCE = 2'd0,
    REG_LOCI      = 2'd1,
    REG_EPISTASIS = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } gva_state_t;

  typedef struct packed {
    logic                       req_type;
    logic [PIECE_W-1:0]         piece_index;
    logic [LOCUS_W-1:0]         locus_index;
    logic signed [EFFECT_W-1:0] effect_value;
    logic [HAP_W-1:0]           haplotype_one;
    logic [HAP_W-1:0]           haplotype_two;
    logic                       last_piece;
  } in_beat_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] genotypic_value;
    logic [TALLY_W-1:0]      homozygous_count;
  } out_beat_t;

  // per-locus control into the term stage
  typedef struct packed {
    logic valid;
    logic hom;
    logic het;
  } term_ctl_t;

  // per-locus status out of the term stage
  typedef struct packed {
    logic valid;
    logic hom;
  } term_res_t;

endpackage

FILE: rtl/core/genotypic_value_accumulator.sv
// ----------------------------------------------------------------------------
// genotypic_value_accumulator
// polygenic score with dominance over an effect table in block memory
// ----------------------------------------------------------------------------
// A load beat writes one effect into the table. A genotype beat walks the
// loci of its piece through the single table read port, one locus per cycle,
// over the first min(loci_in_use, MAX_LOCI) loci: the accept cycle, one read
// per locus, then read data, product register and accumulate. With no locus
// to evaluate, or a piece out of range, it reads nothing. A beat marked
// last_piece then moves the total into the result register, which holds it
// while the next beat is accepted. The table is not cleared: an entry must be
// loaded before a genotype beat reads it.
module genotypic_value_accumulator
  import gva_pkg::*;
#(
  parameter int MAX_PIECES = 64,
  parameter int MAX_LOCI   = 32
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "genotypic_value_accumulator_macros.svh"

  localparam int DEPTH = MAX_PIECES * MAX_LOCI;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LCW   = $clog2(MAX_LOCI + 1);
  localparam logic [8:0]        PIECE_LIM = 9'(MAX_PIECES);
  localparam logic [LOCI_W-1:0] LOCI_LIM  = LOCI_W'(MAX_LOCI);

  gva_state_t state_r, state_nxt;

  logic [DOM_W-1:0]  dom_r;
  logic [LOCI_W-1:0] loci_r;
  logic              epi_r;

  logic [AW-1:0]       base_r;
  logic [LCW-1:0]      n_r, loc_r, n_eff;
  logic [HAP_W-1:0]    hap1_r, hap2_r;
  logic                last_r;
  logic                rd_v_r, rd_b1_r, rd_b2_r;
  logic signed [EFFECT_W-1:0] rd_data_r;

  logic signed [EFFECT_W-1:0] mem [DEPTH];

  term_ctl_t               tctl;
  term_res_t               tres;
  logic signed [SUM_W-1:0] term;

  logic signed [SUM_W-1:0] value_sum_r, hom_sum_r, total;
  logic [TALLY_W-1:0]      tally_r;
  logic                    out_valid_r;
  out_beat_t               out_data_r;

  logic          in_accept, issue, out_load, piece_ok, locus_ok, pipe_empty, cfg_wr;
  logic [AW-1:0] wr_addr, rd_addr;
  cfg_reg_t      cfg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_DOMINANCE: prdata = {16'b0, dom_r};
      REG_LOCI:      prdata = {26'b0, loci_r};
      REG_EPISTASIS: prdata = {31'b0, epi_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dom_r  <= DOM_RESET;
      loci_r <= LOCI_RESET;
      epi_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DOMINANCE: dom_r  <= pwdata[DOM_W-1:0];
        REG_LOCI:      loci_r <= pwdata[LOCI_W-1:0];
        REG_EPISTASIS: epi_r  <= pwdata[0];
        default:       ;
      endcase
    end
  end

  // beat decode
  assign in_accept  = in_valid && !in_stall;
  assign piece_ok   = {3'b000, in_data.piece_index} < PIECE_LIM;
  assign locus_ok   = {1'b0, in_data.locus_index} < LOCI_LIM;
  assign n_eff      = (loci_r > LOCI_LIM) ? LCW'(LOCI_LIM) : LCW'(loci_r);
  assign wr_addr    = AW'(int'(in_data.piece_index) * MAX_LOCI + int'(in_data.locus_index));
  assign rd_addr    = base_r + AW'(loc_r);
  assign pipe_empty = !rd_v_r && !tres.valid;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && in_data.req_type == REQ_GENOTYPE) begin
          state_nxt = (piece_ok && n_eff != '0) ? ST_RUN : ST_DRAIN;
        end
      end
      ST_RUN: begin
        if (loc_r == n_r - LCW'(1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (pipe_empty) state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_RUN:   issue    = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  out_load = !out_valid_r || !out_stall;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      loc_r   <= '0;
      n_r     <= '0;
      last_r  <= 1'b0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      if (in_accept && in_data.req_type == REQ_GENOTYPE) begin
        loc_r  <= '0;
        n_r    <= n_eff;
        last_r <= in_data.last_piece;
      end else if (issue) begin
        loc_r <= loc_r + LCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.req_type == REQ_GENOTYPE) begin
      base_r <= AW'(int'(in_data.piece_index) * MAX_LOCI);
      hap1_r <= in_data.haplotype_one;
      hap2_r <= in_data.haplotype_two;
    end else if (issue) begin
      hap1_r <= hap1_r >> 1;
      hap2_r <= hap2_r >> 1;
    end
    rd_b1_r <= hap1_r[0];
    rd_b2_r <= hap2_r[0];
  end

  // effect table
  always_ff @(posedge clk) begin
    if (in_accept && in_data.req_type == REQ_LOAD && piece_ok && locus_ok) begin
      mem[wr_addr] <= in_data.effect_value;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign tctl.valid = rd_v_r;
  assign tctl.hom   = rd_b1_r && rd_b2_r;
  assign tctl.het   = rd_b1_r ^ rd_b2_r;

  gva_term u_term (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tctl),
    .effect    (rd_data_r),
    .dominance (dom_r),
    .res_r     (tres),
    .term_r    (term)
  );

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_sum_r <= '0;
      hom_sum_r   <= '0;
      tally_r     <= '0;
    end else if (out_load) begin
      value_sum_r <= '0;
      hom_sum_r   <= '0;
      tally_r     <= '0;
    end else if (tres.valid) begin
      value_sum_r <= value_sum_r + term;
      if (tres.hom) begin
        hom_sum_r <= hom_sum_r + term;
        if (tally_r != TALLY_MAX) tally_r <= tally_r + TALLY_W'(1);
      end
    end
  end

  assign total = (epi_r && tally_r >= EPI_THRESHOLD) ? value_sum_r + hom_sum_r : value_sum_r;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.genotypic_value  <= total;
      out_data_r.homozygous_count <= tally_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `GVA_ASSERT_NOW(a_idle_pipe_empty, clk, rst_n, state_r == ST_IDLE, pipe_empty)
  `GVA_ASSERT_NOW(a_run_in_range, clk, rst_n, state_r == ST_RUN, loc_r < n_r)
  `GVA_ASSERT_NEXT(a_clear_after_emit, clk, rst_n, out_load,
    value_sum_r == '0 && hom_sum_r == '0 && tally_r == '0)

endmodule

FILE: rtl/core/gva_term.sv
// ----------------------------------------------------------------------------
// gva_term
// turns one effect and its genotype class into a registered Q32.16 term
// ----------------------------------------------------------------------------
module gva_term
  import gva_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  term_ctl_t                  ctl,
  input  logic signed [EFFECT_W-1:0] effect,
  input  logic [DOM_W-1:0]           dominance,
  output term_res_t                  res_r,
  output logic signed [SUM_W-1:0]    term_r
);

  localparam int PROD_W = EFFECT_W + DOM_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  term_nxt;
  term_res_t                res_nxt;

  always_comb begin
    prod = effect * $signed({1'b0, dominance});
    if (ctl.hom) begin
      term_nxt = SUM_W'(effect);
    end else if (ctl.het) begin
      // floor shift of the Q20.28 product to the Q32.16 term
      term_nxt = {{(SUM_W - PROD_W + FRAC_DOM){prod[PROD_W-1]}}, prod[PROD_W-1:FRAC_DOM]};
    end else begin
      term_nxt = '0;
    end
    res_nxt.valid = ctl.valid;
    res_nxt.hom   = ctl.hom;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the genotypic value accumulator: a queue-fed driver
// and a monitor with random gaps and stalls, an in-bench scorer that tracks
// the effect table, the sums and the tally, and apb register phases in between
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import gva_pkg::*;

  localparam int STUCK_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 64;
  localparam int HOLD_CYCLES = 400;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  genotypic_value_accumulator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // scorer state
  logic [EFFECT_W-1:0] effect_mem [0:2047];
  logic [SUM_W-1:0]    acc_total = '0;
  logic [SUM_W-1:0]    acc_hom   = '0;
  logic [TALLY_W-1:0]  acc_tally = '0;
  logic [DOM_W-1:0]    dom_cfg   = DOM_RESET;
  logic [LOCI_W-1:0]   loci_cfg  = LOCI_RESET;
  logic                epi_cfg   = 1'b0;
  out_beat_t           gv_expected [$];

  // stimulus state
  in_beat_t   beat_queue [$];
  bit         loaded [0:2047];
  int         piece_fill [0:63];
  logic [5:0] ready_pieces [$];

  int        errors      = 0;
  int        beats_moved = 0;
  int        moved_seen  = 0;
  int        stuck_cycles = 0;
  int        send_gap    = 0;
  int        stall_left  = 0;
  int        hold_left   = 0;
  bit        hold_req    = 1'b0;
  bit        quiet_in    = 1'b0;
  bit        quiet_out   = 1'b0;
  out_beat_t want_beat;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] rand_effect();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'hffffffff;
      4: return $urandom_range(0, 131071) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_hap();
    case ($urandom_range(0, 5))
      0: return 32'hffffffff;
      1: return 32'h00000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic score_beat(in_beat_t b);
    int                  n;
    logic [EFFECT_W-1:0] eff;
    logic [SUM_W-1:0]    ext;
    logic signed [63:0]  prod;
    logic [SUM_W-1:0]    total;
    out_beat_t           r;
    if (b.req_type == REQ_LOAD) begin
      effect_mem[{b.piece_index, b.locus_index}] = b.effect_value;
    end else begin
      n = (loci_cfg > 32) ? 32 : loci_cfg;
      for (int l = 0; l < n; l++) begin
        eff = effect_mem[{b.piece_index, l[4:0]}];
        ext = {{(SUM_W-EFFECT_W){eff[EFFECT_W-1]}}, eff};
        if (b.haplotype_one[l] && b.haplotype_two[l]) begin
          acc_total = acc_total + ext;
          acc_hom   = acc_hom + ext;
          if (acc_tally < TALLY_MAX) acc_tally = acc_tally + TALLY_W'(1);
        end else if (b.haplotype_one[l] != b.haplotype_two[l]) begin
          prod = $signed(eff) * $signed({1'b0, dom_cfg});
          acc_total = acc_total + prod[FRAC_DOM+SUM_W-1:FRAC_DOM];
        end
      end
      if (b.last_piece) begin
        total = acc_total;
        if (epi_cfg && acc_tally >= EPI_THRESHOLD) total = total + acc_hom;
        r.genotypic_value  = total;
        r.homozygous_count = acc_tally;
        gv_expected.push_back(r);
        acc_total = '0;
        acc_hom   = '0;
        acc_tally = '0;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        score_beat(in_data);
        beats_moved++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (beat_queue.size() > 0) begin
          in_data  <= beat_queue.pop_front();
          in_valid <= 1'b1;
          send_gap = quiet_in ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_moved++;
        if (gv_expected.size() == 0) begin
          $display("%0t: unexpected result beat, value %0d count %0d", $time,
                   out_data.genotypic_value, out_data.homozygous_count);
          errors++;
        end else begin
          want_beat = gv_expected.pop_front();
          if (out_data.genotypic_value !== want_beat.genotypic_value) begin
            $display("%0t: genotypic_value expected %0d actual %0d", $time,
                     want_beat.genotypic_value, out_data.genotypic_value);
            errors++;
          end
          if (out_data.homozygous_count !== want_beat.homozygous_count) begin
            $display("%0t: homozygous_count expected %0d actual %0d", $time,
                     want_beat.homozygous_count, out_data.homozygous_count);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (beats_moved != moved_seen) begin
      moved_seen   = beats_moved;
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    beats_moved++;
    case (idx)
      REG_DOMINANCE: dom_cfg  = val[DOM_W-1:0];
      REG_LOCI:      loci_cfg = val[LOCI_W-1:0];
      REG_EPISTASIS: epi_cfg  = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] dom, logic [5:0] loci, logic epi);
    write_reg(REG_DOMINANCE, {16'd0, dom});
    write_reg(REG_LOCI, {26'd0, loci});
    write_reg(REG_EPISTASIS, {31'd0, epi});
  endtask

  task automatic drain_phase();
    while (beat_queue.size() > 0 || in_valid || gv_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic queue_load(logic [5:0] piece, logic [4:0] locus, logic [31:0] eff);
    in_beat_t b;
    b.req_type      = REQ_LOAD;
    b.piece_index   = piece;
    b.locus_index   = locus;
    b.effect_value  = eff;
    b.haplotype_one = $urandom;
    b.haplotype_two = $urandom;
    b.last_piece    = 1'($urandom_range(0, 1));
    beat_queue.push_back(b);
    if (!loaded[{piece, locus}]) begin
      loaded[{piece, locus}] = 1'b1;
      piece_fill[piece]++;
      if (piece_fill[piece] == 32) ready_pieces.push_back(piece);
    end
  endtask

  task automatic queue_piece(logic [5:0] piece, logic [31:0] h1, logic [31:0] h2,
                             logic last);
    in_beat_t b;
    b.req_type      = REQ_GENOTYPE;
    b.piece_index   = piece;
    b.locus_index   = 5'($urandom);
    b.effect_value  = $urandom;
    b.haplotype_one = h1;
    b.haplotype_two = h2;
    b.last_piece    = last;
    beat_queue.push_back(b);
  endtask

  task automatic fill_piece(logic [5:0] piece);
    for (int l = 0; l < 32; l++) queue_load(piece, l[4:0], rand_effect());
  endtask

  function automatic logic [5:0] pick_ready();
    return ready_pieces[$urandom_range(0, ready_pieces.size() - 1)];
  endfunction

  task automatic random_phase(int beats);
    int          r;
    logic [31:0] h1;
    logic [31:0] h2;
    for (int k = 0; k < beats; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3 && ready_pieces.size() < 24) begin
        fill_piece(6'($urandom_range(0, 63)));
      end else if (r < 18) begin
        queue_load(6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)), rand_effect());
      end else begin
        h1 = rand_hap();
        case ($urandom_range(0, 3))
          0: h2 = h1;
          1: h2 = ~h1;
          default: h2 = rand_hap();
        endcase
        queue_piece(pick_ready(), h1, h2, $urandom_range(0, 3) == 0);
      end
    end
  endtask

  function automatic logic [15:0] rand_dom();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return DOM_RESET;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [5:0] rand_loci();
    case ($urandom_range(0, 9))
      0: return 6'($urandom_range(0, 1));
      1: return 6'($urandom_range(33, 63));
      2: return 6'd32;
      3: return 6'd2;
      default: return 6'($urandom_range(2, 32));
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config, extreme effects on piece 63
    for (int l = 0; l < 32; l++) queue_load(6'd63, l[4:0], l[0] ? 32'h80000000 : 32'h7fffffff);
    fill_piece(6'd0);
    queue_piece(6'd63, 32'hffffffff, 32'hffffffff, 1'b1);
    queue_piece(6'd63, 32'hffffffff, 32'h00000000, 1'b1);
    queue_piece(6'd63, 32'h00000000, 32'hffffffff, 1'b1);
    queue_piece(6'd63, 32'h00000000, 32'h00000000, 1'b1);
    queue_piece(6'd0, 32'h55555555, 32'hffffffff, 1'b0);
    queue_piece(6'd63, 32'haaaaaaaa, 32'haaaaaaaa, 1'b1);
    queue_load(6'd40, 5'd7, rand_effect());
    queue_piece(6'd0, $urandom, $urandom, 1'b0);
    queue_piece(6'd63, $urandom, $urandom, 1'b1);
    drain_phase();

    // two loci, largest dominance factor, epistasis threshold
    set_config(16'hffff, 6'd2, 1'b1);
    queue_piece(6'd63, 32'h00000003, 32'h00000003, 1'b1);
    queue_piece(6'd63, 32'h00000001, 32'h00000001, 1'b1);
    queue_piece(6'd63, 32'h00000003, 32'h00000000, 1'b1);
    queue_piece(6'd63, 32'hfffffffc, 32'hffffffff, 1'b1);
    drain_phase();

    // loci counts below and above the range
    set_config(16'd0, 6'd0, 1'b1);
    queue_piece(6'd63, 32'hffffffff, 32'hffffffff, 1'b1);
    drain_phase();
    write_reg(REG_LOCI, 32'd1);
    queue_piece(6'd63, 32'hffffffff, 32'hffffffff, 1'b0);
    queue_piece(6'd0, 32'h00000001, 32'h00000000, 1'b1);
    drain_phase();
    write_reg(REG_LOCI, 32'd63);
    queue_piece(6'd63, 32'hffffffff, 32'hffffffff, 1'b1);
    drain_phase();

    // individual spanning a register change, mode taken at emit
    set_config(DOM_RESET, 6'd32, 1'b0);
    queue_piece(6'd0, $urandom, $urandom, 1'b0);
    queue_piece(6'd63, 32'hffff0000, 32'hff00ff00, 1'b0);
    drain_phase();
    set_config(16'd4096, 6'd32, 1'b1);
    queue_piece(6'd0, 32'hffffffff, 32'hffffffff, 1'b1);
    drain_phase();

    for (int ph = 0; ph < 8; ph++) begin
      set_config(rand_dom(), rand_loci(), 1'($urandom_range(0, 1)));
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      random_phase(30);
      drain_phase();
    end

    // receiver holds off while the sender keeps offering beats
    set_config(rand_dom(), 6'd4, 1'($urandom_range(0, 1)));
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    @(negedge clk);
    hold_req = 1'b1;
    for (int k = 0; k < 30; k++) queue_piece(pick_ready(), rand_hap(), rand_hap(), 1'b1);
    drain_phase();
    quiet_in  = 1'b0;
    quiet_out = 1'b0;

    // tally saturation over a long individual
    set_config(rand_dom(), 6'd32, 1'b1);
    for (int k = 0; k < 130; k++) begin
      queue_piece(pick_ready(), 32'hffffffff, 32'hffffffff, k == 129);
    end
    drain_phase();

    set_config(rand_dom(), rand_loci(), 1'($urandom_range(0, 1)));
    random_phase(60);
    drain_phase();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
